[rtl/v3alu_pkg.sv]
// Shared types and codes of the three-component vector unit.
package v3alu_pkg;

   typedef enum logic [2:0] {
      CMD_ADD   = 3'd0,
      CMD_SUB   = 3'd1,
      CMD_NEG   = 3'd2,
      CMD_SCALE = 3'd3,
      CMD_DOT   = 3'd4,
      CMD_CROSS = 3'd5,
      CMD_LEN   = 3'd6,
      CMD_NORM  = 3'd7
   } cmd_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_SAT  = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] scale;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] r_scalar;
      logic        [1:0]  status;
   } rsp_type;

   // Sideband that rides along with the root and divide stages.
   typedef struct packed {
      cmd_type          cmd;
      rsp_type          res;
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
   } side_type;

endpackage

[rtl/v3alu_front.sv]
// Front stages: operand capture, products, sums, shift and saturation.
module v3alu_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  v3alu_pkg::req_type  in_word,
   output logic                out_valid,
   output v3alu_pkg::side_type out_side,
   output logic [63:0]         out_rad
);

   localparam logic signed [65:0] W_MAX = 66'sd2147483647;
   localparam logic signed [65:0] W_MIN = -66'sd2147483648;

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1
   v3alu_pkg::req_type req_ff;
   v3alu_pkg::cmd_type cmd1;
   logic signed [31:0] va [3];
   logic signed [31:0] vb [3];
   logic signed [31:0] op_a [6];
   logic signed [31:0] op_b [6];
   logic signed [32:0] lin_sum [3];
   logic signed [31:0] lin_in [3];
   logic               lin_sat_in;
   logic [2:0][31:0]   mag_in;
   logic [2:0]         neg_in;

   // stage 2
   logic signed [63:0] prod_ff [6];
   logic signed [31:0] lin2_ff [3];
   logic               lin_sat2_ff;
   logic [2:0][31:0]   mag2_ff;
   logic [2:0]         neg2_ff;
   v3alu_pkg::cmd_type cmd2_ff;
   logic signed [65:0] ext [6];
   logic signed [65:0] sum_in [3];

   // stage 3
   logic signed [65:0] sum_ff [3];
   logic signed [31:0] lin3_ff [3];
   logic               lin_sat3_ff;
   logic [2:0][31:0]   mag3_ff;
   logic [2:0]         neg3_ff;
   v3alu_pkg::cmd_type cmd3_ff;
   logic signed [65:0] sh [3];
   logic [2:0]         ov;
   logic signed [31:0] sat_v [3];
   v3alu_pkg::side_type side_in;

   // stage 4
   v3alu_pkg::side_type side_ff;
   logic [63:0]         rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      cmd1  = v3alu_pkg::cmd_type'(req_ff.cmd);
      va[0] = req_ff.a_x;
      va[1] = req_ff.a_y;
      va[2] = req_ff.a_z;
      vb[0] = req_ff.b_x;
      vb[1] = req_ff.b_y;
      vb[2] = req_ff.b_z;
      for (int k = 0; k < 6; k++) begin
         op_a[k] = '0;
         op_b[k] = '0;
      end
      case (cmd1)
         v3alu_pkg::CMD_SCALE: begin
            for (int k = 0; k < 3; k++) begin
               op_a[k] = va[k];
               op_b[k] = req_ff.scale;
            end
         end
         v3alu_pkg::CMD_DOT: begin
            for (int k = 0; k < 3; k++) begin
               op_a[k] = va[k];
               op_b[k] = vb[k];
            end
         end
         v3alu_pkg::CMD_CROSS: begin
            op_a[0] = va[1]; op_b[0] = vb[2];
            op_a[1] = va[2]; op_b[1] = vb[1];
            op_a[2] = va[2]; op_b[2] = vb[0];
            op_a[3] = va[0]; op_b[3] = vb[2];
            op_a[4] = va[0]; op_b[4] = vb[1];
            op_a[5] = va[1]; op_b[5] = vb[0];
         end
         default: begin
            // squares for length and normalize
            for (int k = 0; k < 3; k++) begin
               op_a[k] = va[k];
               op_b[k] = va[k];
            end
         end
      endcase

      lin_sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         case (cmd1)
            v3alu_pkg::CMD_SUB: lin_sum[k] = {va[k][31], va[k]} - {vb[k][31], vb[k]};
            v3alu_pkg::CMD_NEG: lin_sum[k] = 33'sd0 - {va[k][31], va[k]};
            default:            lin_sum[k] = {va[k][31], va[k]} + {vb[k][31], vb[k]};
         endcase
         if (lin_sum[k][32] != lin_sum[k][31]) begin
            lin_in[k]  = lin_sum[k][32] ? v3alu_pkg::Q_MIN : v3alu_pkg::Q_MAX;
            lin_sat_in = 1'b1;
         end else begin
            lin_in[k] = lin_sum[k][31:0];
         end
         neg_in[k] = va[k][31];
         mag_in[k] = va[k][31] ? (~va[k] + 32'd1) : va[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req_ff <= in_word;
         for (int k = 0; k < 6; k++) begin
            prod_ff[k] <= op_a[k] * op_b[k];
         end
         for (int k = 0; k < 3; k++) begin
            lin2_ff[k] <= lin_in[k];
         end
         lin_sat2_ff <= lin_sat_in;
         mag2_ff     <= mag_in;
         neg2_ff     <= neg_in;
         cmd2_ff     <= cmd1;
      end
   end

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         ext[k] = {{2{prod_ff[k][63]}}, prod_ff[k]};
      end
      case (cmd2_ff)
         v3alu_pkg::CMD_CROSS: begin
            sum_in[0] = ext[0] - ext[1];
            sum_in[1] = ext[2] - ext[3];
            sum_in[2] = ext[4] - ext[5];
         end
         v3alu_pkg::CMD_DOT, v3alu_pkg::CMD_LEN, v3alu_pkg::CMD_NORM: begin
            sum_in[0] = ext[0] + ext[1] + ext[2];
            sum_in[1] = '0;
            sum_in[2] = '0;
         end
         default: begin
            sum_in[0] = ext[0];
            sum_in[1] = ext[1];
            sum_in[2] = ext[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            sum_ff[k]  <= sum_in[k];
            lin3_ff[k] <= lin2_ff[k];
         end
         lin_sat3_ff <= lin_sat2_ff;
         mag3_ff     <= mag2_ff;
         neg3_ff     <= neg2_ff;
         cmd3_ff     <= cmd2_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh[k] = sum_ff[k] >>> FRAC_BITS;
         ov[k] = (sh[k] > W_MAX) || (sh[k] < W_MIN);
         if (ov[k]) begin
            sat_v[k] = sh[k][65] ? v3alu_pkg::Q_MIN : v3alu_pkg::Q_MAX;
         end else begin
            sat_v[k] = sh[k][31:0];
         end
      end
      side_in     = '0;
      side_in.cmd = cmd3_ff;
      side_in.mag = mag3_ff;
      side_in.neg = neg3_ff;
      case (cmd3_ff)
         v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB, v3alu_pkg::CMD_NEG: begin
            side_in.res.r_x    = lin3_ff[0];
            side_in.res.r_y    = lin3_ff[1];
            side_in.res.r_z    = lin3_ff[2];
            side_in.res.status = lin_sat3_ff ? v3alu_pkg::STATUS_SAT : v3alu_pkg::STATUS_OK;
         end
         v3alu_pkg::CMD_SCALE, v3alu_pkg::CMD_CROSS: begin
            side_in.res.r_x    = sat_v[0];
            side_in.res.r_y    = sat_v[1];
            side_in.res.r_z    = sat_v[2];
            side_in.res.status = (|ov) ? v3alu_pkg::STATUS_SAT : v3alu_pkg::STATUS_OK;
         end
         v3alu_pkg::CMD_DOT: begin
            side_in.res.r_scalar = sat_v[0];
            side_in.res.status   = ov[0] ? v3alu_pkg::STATUS_SAT : v3alu_pkg::STATUS_OK;
         end
         default: begin
            // length and normalize finish after the root
            side_in.res.status = v3alu_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= side_in;
         rad_ff  <= sum_ff[0][63:0];
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = side_ff;
   assign out_rad   = rad_ff;

endmodule

[rtl/v3alu_sqrt.sv]
// Pipelined integer square root, two root bits per stage.
module v3alu_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  v3alu_pkg::side_type in_side,
   input  logic [63:0]         in_rad,
   output logic                out_valid,
   output v3alu_pkg::side_type out_side,
   output logic [31:0]         out_root
);

   localparam int STAGES = 16;

   logic                v_ff    [STAGES];
   v3alu_pkg::side_type side_ff [STAGES];
   logic [63:0]         rad_ff  [STAGES];
   logic [34:0]         rem_ff  [STAGES];
   logic [31:0]         root_ff [STAGES];

   function automatic logic [66:0] sq_step(input logic [34:0] rem, input logic [31:0] root,
                                           input logic [1:0] pair);
      logic [34:0] cand;
      logic [34:0] trial;
      logic [34:0] rem_o;
      logic [31:0] root_o;
      cand  = {rem[32:0], pair};
      trial = {1'b0, root, 2'b01};
      if (cand >= trial) begin
         rem_o  = cand - trial;
         root_o = {root[30:0], 1'b1};
      end else begin
         rem_o  = cand;
         root_o = {root[30:0], 1'b0};
      end
      return {rem_o, root_o};
   endfunction

   for (genvar s = 0; s < STAGES; s++) begin : g_st
      localparam int J0 = 31 - 2 * s;
      localparam int J1 = 30 - 2 * s;
      logic                v_prev;
      v3alu_pkg::side_type side_prev;
      logic [63:0]         rad_prev;
      logic [34:0]         rem_prev;
      logic [31:0]         root_prev;
      logic [66:0]         mid;
      logic [66:0]         fin;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign side_prev = in_side;
         assign rad_prev  = in_rad;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_rest
         assign v_prev    = v_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      always_comb begin
         mid = sq_step(rem_prev, root_prev, rad_prev[2*J0+1 -: 2]);
         fin = sq_step(mid[66:32], mid[31:0], rad_prev[2*J1+1 -: 2]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s] <= side_prev;
            rad_ff[s]  <= rad_prev;
            rem_ff[s]  <= fin[66:32];
            root_ff[s] <= fin[31:0];
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];

endmodule

[rtl/v3alu_norm.sv]
// Restoring divide stages for normalize, the length result, then the output register.
module v3alu_norm #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  v3alu_pkg::side_type in_side,
   input  logic [31:0]         in_root,
   output logic                out_valid,
   output v3alu_pkg::rsp_type  out_word
);

   localparam int DSTAGES = FRAC_BITS + 1;
   localparam int QW      = FRAC_BITS + 1;

   logic                v_ff    [DSTAGES];
   v3alu_pkg::side_type side_ff [DSTAGES];
   logic [31:0]         root_ff [DSTAGES];
   logic [2:0][31:0]    rem_ff  [DSTAGES];
   logic [2:0][QW-1:0]  q_ff    [DSTAGES];

   for (genvar s = 0; s < DSTAGES; s++) begin : g_st
      logic                v_prev;
      v3alu_pkg::side_type side_prev;
      logic [31:0]         root_prev;
      logic [2:0][31:0]    rem_in;
      logic [2:0][QW-1:0]  q_in;

      if (s == 0) begin : g_first
         // leading quotient bit: magnitude never exceeds the length
         assign v_prev    = in_valid;
         assign side_prev = in_side;
         assign root_prev = in_root;
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               if (in_side.mag[k] >= in_root) begin
                  rem_in[k] = in_side.mag[k] - in_root;
                  q_in[k]   = QW'(1);
               end else begin
                  rem_in[k] = in_side.mag[k];
                  q_in[k]   = '0;
               end
            end
         end
      end else begin : g_rest
         logic [32:0] rem2 [3];
         assign v_prev    = v_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign root_prev = root_ff[s-1];
         always_comb begin
            for (int k = 0; k < 3; k++) begin
               rem2[k] = {rem_ff[s-1][k], 1'b0};
               if (rem2[k] >= {1'b0, root_ff[s-1]}) begin
                  rem_in[k] = 32'(rem2[k] - {1'b0, root_ff[s-1]});
                  q_in[k]   = {q_ff[s-1][k][QW-2:0], 1'b1};
               end else begin
                  rem_in[k] = rem2[k][31:0];
                  q_in[k]   = {q_ff[s-1][k][QW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s] <= side_prev;
            root_ff[s] <= root_prev;
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= q_in;
         end
      end
   end

   v3alu_pkg::side_type last_side;
   logic [31:0]         last_root;
   logic [2:0][QW-1:0]  last_q;
   logic signed [31:0]  qv [3];
   v3alu_pkg::rsp_type  rsp_in;
   v3alu_pkg::rsp_type  rsp_ff;
   logic                rsp_v_ff;

   assign last_side = side_ff[DSTAGES-1];
   assign last_root = root_ff[DSTAGES-1];
   assign last_q    = q_ff[DSTAGES-1];

   always_comb begin
      rsp_in = last_side.res;
      for (int k = 0; k < 3; k++) begin
         qv[k] = {{(32-QW){1'b0}}, last_q[k]};
         if (last_side.neg[k]) begin
            qv[k] = -qv[k];
         end
      end
      case (last_side.cmd)
         v3alu_pkg::CMD_LEN: begin
            rsp_in.r_scalar = last_root[31] ? v3alu_pkg::Q_MAX : last_root;
            rsp_in.status   = last_root[31] ? v3alu_pkg::STATUS_SAT : v3alu_pkg::STATUS_OK;
         end
         v3alu_pkg::CMD_NORM: begin
            if (last_root == 32'd0) begin
               rsp_in.status = v3alu_pkg::STATUS_ZERO;
            end else begin
               rsp_in.r_x    = qv[0];
               rsp_in.r_y    = qv[1];
               rsp_in.r_z    = qv[2];
               rsp_in.status = v3alu_pkg::STATUS_OK;
            end
         end
         default: begin
            rsp_in = last_side.res;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= v_ff[DSTAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_v_ff;
   assign out_word  = rsp_ff;

endmodule

[rtl/vector3_alu_unit.sv]
// Top level of the pipelined three-component fixed-point vector unit.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_ready  v3alu_pkg::req_type
//   rsp      out        rsp_valid / rsp_ready  v3alu_pkg::rsp_type
//
// One word enters per cycle unless a stalled rsp word holds the pipe. The depth
// is set by the square root, which settles two root bits per stage over 16
// stages, and by the normalize divide, which settles one quotient bit per
// stage over FRAC_BITS + 1 stages.
// Synchronous reset clears every stage valid bit; data registers keep junk.
// A stalled rsp word freezes the whole pipe in place, so req_ready drops only
// while a result sits in the output register unaccepted.
module vector3_alu_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  v3alu_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output v3alu_pkg::rsp_type rsp_word
);

   logic                adv;
   logic                fr_valid;
   v3alu_pkg::side_type fr_side;
   logic [63:0]         fr_rad;
   logic                sq_valid;
   v3alu_pkg::side_type sq_side;
   logic [31:0]         sq_root;

   // advance every stage unless the output word is held
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // products, sums, shift and saturate; finishes every non-root command
   v3alu_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_rad   (fr_rad)
   );

   // floor square root of the sum of squares
   v3alu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_rad    (fr_rad),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   // length result, normalize divide and the output register
   v3alu_norm #(
      .FRAC_BITS (FRAC_BITS)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_side   (sq_side),
      .in_root   (sq_root),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

endmodule

[rtl/v3alu_checker.sv]
// Port-level checks of the vector unit and their binding to the top level.
module v3alu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input v3alu_pkg::rsp_type rsp_word
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   // an empty output register never blocks the input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with output empty");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status <= v3alu_pkg::STATUS_ZERO)
      else $error("undefined status code");

   // zero-length normalize gives an all-zero result
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == v3alu_pkg::STATUS_ZERO |->
         rsp_word.r_x == 32'sd0 && rsp_word.r_y == 32'sd0 &&
         rsp_word.r_z == 32'sd0 && rsp_word.r_scalar == 32'sd0)
      else $error("zero-length normalize with nonzero fields");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind vector3_alu_unit v3alu_checker u_checker (.*);
